// ===== hdl/b32c_pkg.sv =====
// b32c_pkg: shared types, register indexes and helpers of the base32 stream codec.
// Used by every module of the codec; depends on nothing.
`default_nettype none

package b32c_pkg;

  localparam int SYM_W      = 8;
  localparam int GROUP_W    = 5;
  localparam int ALPHA_SIZE = 32;
  localparam int ALPHA_W    = ALPHA_SIZE * SYM_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA0    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA1    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA2    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA3    = 3'd4;

  localparam logic DIR_ENCODE = 1'b0;

  typedef logic [ALPHA_W-1:0] alpha_t;

  typedef struct packed {
    logic               enc;
    logic               two;
    logic               err;
    logic [SYM_W-1:0]   d0;
    logic [GROUP_W-1:0] d1;
  } job_t;

  function automatic logic [SYM_W-1:0] alpha_char(alpha_t a, logic [GROUP_W-1:0] i);
    return a[{i, 3'b000} +: SYM_W];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/b32c_front.sv =====
// b32c_front: accepts input words, updates the encoder and decoder bit stores
// and turns each word that yields a result into a result job. Depends on b32c_pkg.
`default_nettype none

module b32c_front
  import b32c_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             direction,
  input  wire alpha_t           alpha,
  input  wire logic             accept,
  input  wire logic [SYM_W-1:0] symbol,
  input  wire logic             flush,
  output logic                  push,
  output job_t                  job
);

  logic [3:0]  enc_bits_r, enc_bits_nxt;
  logic [2:0]  enc_count_r, enc_count_nxt;
  logic [11:0] dec_bits_r, dec_bits_nxt;
  logic [3:0]  dec_count_r, dec_count_nxt;

  logic [11:0] ebits;
  logic [3:0]  esh;
  logic [3:0]  erem;
  logic        etwo;
  logic [4:0]  eflush_val;
  logic [2:0]  eflush_sh;

  logic [4:0]  didx;
  logic        dfound;
  logic [3:0]  dcnt;
  logic [3:0]  dnew;
  logic [11:0] dbits;

  always_comb begin
    ebits      = {enc_bits_r, symbol};
    esh        = 4'(enc_count_r) + 4'd3;
    etwo       = (enc_count_r >= 3'd2);
    erem       = etwo ? 4'(enc_count_r) - 4'd2 : 4'(enc_count_r) + 4'd3;
    eflush_sh  = 3'd5 - enc_count_r;
    eflush_val = 5'(enc_bits_r) << eflush_sh;
  end

  always_comb begin
    didx   = '0;
    dfound = 1'b0;
    for (int i = 0; i < ALPHA_SIZE; i++) begin
      if (alpha_char(alpha, 5'(i)) == symbol) begin
        didx   = 5'(i);
        dfound = 1'b1;
      end
    end
    dcnt  = ((dec_count_r > 4'd7) ? 4'd7 : dec_count_r) + 4'd5;
    dbits = {dec_bits_r[6:0], didx};
    dnew  = dcnt - 4'd8;
  end

  always_comb begin
    enc_bits_nxt  = enc_bits_r;
    enc_count_nxt = enc_count_r;
    dec_bits_nxt  = dec_bits_r;
    dec_count_nxt = dec_count_r;
    push          = 1'b0;
    job           = '0;
    if (accept) begin
      if (direction == DIR_ENCODE) begin
        job.enc = 1'b1;
        if (flush) begin
          enc_bits_nxt  = '0;
          enc_count_nxt = '0;
          if (enc_count_r != 3'd0 && enc_count_r <= 3'd4) begin
            push   = 1'b1;
            job.d0 = 8'(eflush_val);
          end
        end else begin
          push          = 1'b1;
          job.two       = etwo;
          job.d0        = 8'(5'(ebits >> esh));
          job.d1        = 5'(ebits >> (esh - 4'd5));
          enc_count_nxt = 3'(erem);
          enc_bits_nxt  = 4'(ebits & ((12'd1 << erem) - 12'd1));
        end
      end else begin
        if (flush) begin
          dec_bits_nxt  = '0;
          dec_count_nxt = '0;
        end else if (!dfound) begin
          push    = 1'b1;
          job.err = 1'b1;
        end else if (dcnt >= 4'd8) begin
          push          = 1'b1;
          job.d0        = 8'(dbits >> dnew);
          dec_count_nxt = dnew;
          dec_bits_nxt  = dbits & ((12'd1 << dnew) - 12'd1);
        end else begin
          dec_count_nxt = dcnt;
          dec_bits_nxt  = dbits;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_bits_r  <= '0;
      enc_count_r <= '0;
      dec_bits_r  <= '0;
      dec_count_r <= '0;
    end else begin
      enc_bits_r  <= enc_bits_nxt;
      enc_count_r <= enc_count_nxt;
      dec_bits_r  <= dec_bits_nxt;
      dec_count_r <= dec_count_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/b32c_queue.sv =====
// b32c_queue: short job queue between the front and the back of the codec.
// Depends on b32c_pkg.
`default_nettype none

module b32c_queue
  import b32c_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t wr_job,
  output logic      full,
  input  wire logic pop,
  output logic      rd_valid,
  output job_t      rd_job
);

  job_t               mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_PTR_W:0]   count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign full     = (count_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_job   = mem[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && rd_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (Q_PTR_W+1)'(do_push) - (Q_PTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/b32c_back.sv =====
// b32c_back: expands queued jobs into result words, one per cycle unless out_ready stalls,
// through an output register with alphabet lookup for encode jobs. Depends on b32c_pkg.
`default_nettype none

module b32c_back
  import b32c_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire alpha_t      alpha,
  input  wire logic        q_valid,
  input  wire job_t        q_job,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [SYM_W-1:0] out_symbol,
  output logic             out_err,
  output logic             out_last
);

  logic               out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]   out_sym_r;
  logic               out_err_r;
  logic               out_last_r;
  logic               second_r, second_nxt;
  logic               load;
  logic [GROUP_W-1:0] sel_idx;
  logic [SYM_W-1:0]   sym;
  logic               fin;

  always_comb begin
    load          = q_valid && (!out_valid_r || out_ready);
    sel_idx       = second_r ? q_job.d1 : q_job.d0[GROUP_W-1:0];
    fin           = !(q_job.two && !second_r);
    pop           = load && fin;
    second_nxt    = load ? !fin : second_r;
    out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    if (q_job.enc) begin
      sym = alpha_char(alpha, sel_idx);
    end else if (q_job.err) begin
      sym = '0;
    end else begin
      sym = q_job.d0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_sym_r  <= sym;
      out_err_r  <= q_job.err;
      out_last_r <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      second_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      second_r    <= second_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = out_sym_r;
  assign out_err    = out_err_r;
  assign out_last   = out_last_r;

endmodule

`default_nettype wire

// ===== hdl/base32_stream_codec.sv =====
// base32_stream_codec: top level; holds the configuration registers and joins
// front, job queue and back. Depends on b32c_pkg, b32c_front, b32c_queue, b32c_back.
// Path: the front writes each result job into the queue; the back loads it into the
// output register. Throughput: one word per cycle while the queue is not full; one
// result word per cycle out of a single output register unless out_tready stalls.
// Reset: synchronous rst_n clears registers, bit stores, queue and output valid.
`default_nettype none

module base32_stream_codec
  import b32c_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [7:0]            in_tdata,   // [7:0] symbol
  input  wire logic                  in_tuser,   // [0] flush
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [7:0]                 out_tdata,  // [7:0] out_symbol
  output logic                       out_tuser,  // [0] error
  output logic                       out_tlast,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic   direction_r, direction_nxt;
  alpha_t alpha_r, alpha_nxt;
  logic   accept;
  logic   push;
  job_t   wr_job;
  logic   full;
  logic   pop;
  logic   q_valid;
  job_t   q_job;

  assign cfg_ready = 1'b1;
  assign in_tready = !full;
  assign accept    = in_tvalid && !full;

  always_comb begin
    direction_nxt = direction_r;
    alpha_nxt     = alpha_r;
    if (cfg_valid) begin
      case (cfg_addr)
        REG_DIRECTION: direction_nxt = cfg_data[0];
        REG_ALPHA0:    alpha_nxt[0*CFG_DATA_W +: CFG_DATA_W] = cfg_data;
        REG_ALPHA1:    alpha_nxt[1*CFG_DATA_W +: CFG_DATA_W] = cfg_data;
        REG_ALPHA2:    alpha_nxt[2*CFG_DATA_W +: CFG_DATA_W] = cfg_data;
        REG_ALPHA3:    alpha_nxt[3*CFG_DATA_W +: CFG_DATA_W] = cfg_data;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= DIR_ENCODE;
      alpha_r     <= '0;
    end else begin
      direction_r <= direction_nxt;
      alpha_r     <= alpha_nxt;
    end
  end

  b32c_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .direction (direction_r),
    .alpha     (alpha_r),
    .accept    (accept),
    .symbol    (in_tdata),
    .flush     (in_tuser),
    .push      (push),
    .job       (wr_job)
  );

  b32c_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_job   (wr_job),
    .full     (full),
    .pop      (pop),
    .rd_valid (q_valid),
    .rd_job   (q_job)
  );

  b32c_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .alpha      (alpha_r),
    .q_valid    (q_valid),
    .q_job      (q_job),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_symbol (out_tdata),
    .out_err    (out_tuser),
    .out_last   (out_tlast)
  );

endmodule

`default_nettype wire

// ===== hdl/b32c_checker.sv =====
// b32c_props: port-level assertions for base32_stream_codec, bound to the top level.
// Depends on the top level's ports only.
`default_nettype none

module b32c_props (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tuser,
  input wire logic       out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result word changed while stalled");

  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata == 8'd0))
    else $error("error word not a single zero result");

  a_first_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !out_tuser)
    else $error("error flagged on first of two characters");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind base32_stream_codec b32c_props u_b32c_props (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

// ===== tb/b32c_checker.sv =====
`timescale 1ns / 100ps
// b32c_checker: watches the configuration, input and result channels of the base32
// stream codec, predicts every result word and compares it in arrival order.
// Depends on b32c_pkg for register indexes, widths and the alphabet type.
module b32c_checker
  import b32c_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] symbol
  input  logic                  in_tuser,   // [0] flush
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [7:0]            out_tdata,  // [7:0] out_symbol
  input  logic                  out_tuser,  // [0] error
  input  logic                  out_tlast,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    words_due
);

  localparam int NO_MATCH = -1;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             err;
    logic             last;
  } codec_word_t;

  codec_word_t due_q[$];
  int          fails;
  logic        dir;
  alpha_t      alpha;
  logic [3:0]  enc_bits;
  int          enc_cnt;
  logic [11:0] dec_bits;
  int          dec_cnt;

  function automatic logic [SYM_W-1:0] char_at(input logic [GROUP_W-1:0] idx);
    return alpha[{idx, 3'b000} +: SYM_W];
  endfunction

  // highest matching position wins
  function automatic int index_of(input logic [SYM_W-1:0] ch);
    int found;
    logic [GROUP_W-1:0] pos;
    found = NO_MATCH;
    for (int i = 0; i < ALPHA_SIZE; i++) begin
      pos = i[GROUP_W-1:0];
      if (char_at(pos) == ch) found = i;
    end
    return found;
  endfunction

  task automatic predict_codec_words(input logic [SYM_W-1:0] sym, input logic flush);
    logic [11:0]        acc;
    logic [11:0]        sh;
    logic [GROUP_W-1:0] grp;
    int                 cnt;
    int                 n;
    int                 idx;
    codec_word_t        w;
    if (dir == DIR_ENCODE) begin
      if (flush) begin
        if (enc_cnt != 0) begin
          grp = {1'b0, enc_bits} << (GROUP_W - enc_cnt);
          w.sym = char_at(grp);
          w.err = 1'b0;
          w.last = 1'b1;
          due_q.push_back(w);
        end
        enc_bits = '0;
        enc_cnt = 0;
      end else begin
        acc = {enc_bits, sym};
        cnt = enc_cnt + 8;
        n = (cnt >= 2 * GROUP_W) ? 2 : 1;
        for (int k = 0; k < n; k++) begin
          sh = acc >> (cnt - GROUP_W);
          w.sym = char_at(sh[GROUP_W-1:0]);
          w.err = 1'b0;
          w.last = (k == n - 1);
          due_q.push_back(w);
          cnt -= GROUP_W;
        end
        sh = acc & ((12'd1 << cnt) - 12'd1);
        enc_bits = sh[3:0];
        enc_cnt = cnt;
      end
    end else begin
      if (flush) begin
        dec_bits = '0;
        dec_cnt = 0;
      end else begin
        idx = index_of(sym);
        if (idx == NO_MATCH) begin
          w.sym = '0;
          w.err = 1'b1;
          w.last = 1'b1;
          due_q.push_back(w);
        end else begin
          acc = {dec_bits[6:0], idx[GROUP_W-1:0]};
          cnt = dec_cnt + GROUP_W;
          if (cnt >= 8) begin
            sh = acc >> (cnt - 8);
            w.sym = sh[7:0];
            w.err = 1'b0;
            w.last = 1'b1;
            due_q.push_back(w);
            cnt -= 8;
            acc = acc & ((12'd1 << cnt) - 12'd1);
          end
          dec_bits = acc;
          dec_cnt = cnt;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    codec_word_t got;
    codec_word_t want;
    if (!rst_n) begin
      due_q.delete();
      fails = 0;
      dir = DIR_ENCODE;
      alpha = '0;
      enc_bits = '0;
      enc_cnt = 0;
      dec_bits = '0;
      dec_cnt = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          REG_DIRECTION: dir = cfg_data[0];
          REG_ALPHA0:    alpha[0 +: CFG_DATA_W] = cfg_data;
          REG_ALPHA1:    alpha[CFG_DATA_W +: CFG_DATA_W] = cfg_data;
          REG_ALPHA2:    alpha[2 * CFG_DATA_W +: CFG_DATA_W] = cfg_data;
          REG_ALPHA3:    alpha[3 * CFG_DATA_W +: CFG_DATA_W] = cfg_data;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.sym = out_tdata;
        got.err = out_tuser;
        got.last = out_tlast;
        if (due_q.size() == 0) begin
          $display("%0t: unexpected result word: expected none, got sym %02h err %0b last %0b",
                   $time, got.sym, got.err, got.last);
          fails++;
        end else begin
          want = due_q.pop_front();
          if (got.sym !== want.sym || got.err !== want.err || got.last !== want.last) begin
            $display("%0t: result mismatch: expected sym %02h err %0b last %0b, got sym %02h err %0b last %0b",
                     $time, want.sym, want.err, want.last, got.sym, got.err, got.last);
            fails++;
          end
        end
      end
      if (in_tvalid && in_tready) predict_codec_words(in_tdata, in_tuser);
    end
    fail_count <= fails;
    words_due <= due_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: drives configuration and input words into base32_stream_codec under
// random idling, and gives the verdict. Depends on b32c_pkg and b32c_checker.
module tb_top
  import b32c_pkg::*;
();

  localparam logic                 DIR_DECODE    = ~DIR_ENCODE;
  localparam logic                 DATA_ITEM     = 1'b0;
  localparam logic                 FLUSH_ITEM    = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED    = '1;
  localparam int                   SETTLE_CYCLES = 8;
  localparam int                   HOLD_CYCLES   = 300;
  localparam int                   QUIET_LIMIT   = 2000;
  localparam int                   SEGMENTS      = 6;
  localparam int                   SEG_ITEMS     = 110;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [7:0]            in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [7:0]            out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  cfg_ready;
  int                    fail_count;
  int                    words_due;

  int     tx_idle_pct = 0;
  int     rx_idle_pct = 0;
  logic   rx_hold     = 1'b0;
  logic   hold_done   = 1'b0;
  int     hold_left   = 0;
  int     quiet_cycles = 0;
  logic   cur_dir     = DIR_ENCODE;
  alpha_t cur_alpha   = '0;

  always #4 clk = ~clk;

  base32_stream_codec uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  b32c_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .words_due  (words_due)
  );

  // hold off once for a long stretch when asked, else stall at random
  always @(posedge clk) begin
    if (rx_hold && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic [7:0] sym, input logic flush);
    cfg_valid <= 1'b0;
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= sym;
    in_tuser <= flush;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // drain all expected words, then let in-flight words without results retire
  task automatic settle();
    in_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic switch_dir(input logic d);
    logic [CFG_DATA_W-1:0] val;
    val = {$urandom, $urandom};
    val[0] = d;
    settle();
    cfg_write(REG_DIRECTION, val);
    cur_dir = d;
  endtask

  task automatic configure(input logic d, input alpha_t a);
    switch_dir(d);
    cfg_write(REG_ALPHA0, a[0 +: CFG_DATA_W]);
    cfg_write(REG_ALPHA1, a[CFG_DATA_W +: CFG_DATA_W]);
    cfg_write(REG_ALPHA2, a[2 * CFG_DATA_W +: CFG_DATA_W]);
    cfg_write(REG_ALPHA3, a[3 * CFG_DATA_W +: CFG_DATA_W]);
    cur_alpha = a;
  endtask

  function automatic alpha_t std_alphabet();
    alpha_t a;
    for (int i = 0; i < ALPHA_SIZE; i++)
      a[i * SYM_W +: SYM_W] = 8'((i < 26) ? "A" + i : "2" + i - 26);
    return a;
  endfunction

  function automatic alpha_t make_alphabet(input int kind);
    alpha_t a;
    case (kind)
      0: a = std_alphabet();
      1: for (int i = 0; i < ALPHA_W / 32; i++) a[i * 32 +: 32] = $urandom;
      2: for (int i = 0; i < ALPHA_SIZE; i++) a[i * SYM_W +: SYM_W] = 8'($urandom_range("P", "A"));
      default: a = $urandom_range(1, 0) ? '1 : '0;
    endcase
    return a;
  endfunction

  task automatic send_random_word();
    int                 r;
    logic [GROUP_W-1:0] pos;
    r = $urandom_range(99, 0);
    pos = GROUP_W'($urandom_range(ALPHA_SIZE - 1, 0));
    if (cur_dir == DIR_ENCODE) begin
      send_word(8'($urandom), (r < 8) ? FLUSH_ITEM : DATA_ITEM);
    end else if (r < 5) begin
      send_word(8'($urandom), FLUSH_ITEM);
    end else if (r < 15) begin
      send_word(8'($urandom), DATA_ITEM);
    end else begin
      send_word(cur_alpha[{pos, 3'b000} +: SYM_W], DATA_ITEM);
    end
  endtask

  initial begin : stimulus
    logic d;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset alphabet: every character is zero
    send_word(8'hFF, DATA_ITEM);
    send_word(8'h00, FLUSH_ITEM);
    switch_dir(DIR_DECODE);
    send_word(8'h00, DATA_ITEM);
    send_word(8'h00, DATA_ITEM);
    send_word("A", DATA_ITEM);
    send_word(8'h5C, FLUSH_ITEM);

    configure(DIR_ENCODE, std_alphabet());
    send_word(8'h00, DATA_ITEM);
    send_word(8'hFF, DATA_ITEM);
    send_word(8'h5A, DATA_ITEM);
    send_word(8'hC3, DATA_ITEM);
    send_word(8'h00, FLUSH_ITEM);
    send_word(8'hFF, FLUSH_ITEM);

    // leave bits pending on both sides across direction changes
    send_word(8'h81, DATA_ITEM);
    switch_dir(DIR_DECODE);
    send_word("Z", DATA_ITEM);
    send_word("2", DATA_ITEM);
    send_word("=", DATA_ITEM);
    send_word("a", DATA_ITEM);
    switch_dir(DIR_ENCODE);
    send_word(8'h00, FLUSH_ITEM);
    settle();
    cfg_write(REG_UNUSED, '1);
    switch_dir(DIR_DECODE);
    send_word("7", DATA_ITEM);
    send_word("A", DATA_ITEM);
    send_word(8'hFF, DATA_ITEM);
    send_word(8'h00, FLUSH_ITEM);
    send_word(8'h00, FLUSH_ITEM);

    configure(DIR_DECODE, '1);
    send_word(8'hFF, DATA_ITEM);
    send_word(8'hFE, DATA_ITEM);
    send_word(8'hFF, DATA_ITEM);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 10;
          rx_idle_pct <= 87;
        end
        1: begin
          tx_idle_pct = 87;
          rx_idle_pct <= 10;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct <= 0;
        end
      endcase
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        d = (ph == 2 && seg == 2) ? DIR_ENCODE : 1'($urandom_range(1, 0));
        configure(d, make_alphabet($urandom_range(3, 0)));
        if ($urandom_range(3, 0) == 0)
          cfg_write(CFG_IDX_W'($urandom_range(REG_UNUSED, REG_ALPHA3 + 1)),
                    {$urandom, $urandom});
        if (ph == 2 && seg == 2) rx_hold <= 1'b1;
        for (int i = 0; i < SEG_ITEMS; i++) send_random_word();
      end
    end

    settle();
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/b32c_pkg.sv
hdl/b32c_front.sv
hdl/b32c_queue.sv
hdl/b32c_back.sv
hdl/base32_stream_codec.sv
hdl/b32c_checker.sv
tb/b32c_checker.sv
tb/tb_top.sv
